>>> src/dtou_pkg.sv
// ----------------------------------------------------------------------------
// Definite-time over/under relay package
// Shared constants, item types and stage control types for the relay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtou_pkg;

    localparam int STAGES = 4;
    localparam int NQ     = 4;
    localparam int NSTG   = NQ * STAGES;
    localparam int NMASK  = (NSTG < 16) ? NSTG : 16;

    localparam logic [15:0] ONE_PU   = 16'd4096;
    localparam logic [15:0] TWO_PU   = 16'd8192;
    localparam logic [15:0] ELAP_MAX = 16'hFFFF;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    localparam int Q_VOLTAGE = 3;

    typedef struct packed {
        logic        func;
        logic [15:0] wind_speed;
        logic [15:0] rotor_speed;
        logic [15:0] bus_frequency;
        logic [15:0] terminal_voltage;
        logic        unit_online;
        logic [1:0]  set_quantity;
        logic [1:0]  set_stage;
        logic [15:0] set_threshold;
        logic [15:0] set_delay;
    } t_in_item;

    typedef struct packed {
        logic        tripped;
        logic        trip_now;
        logic [3:0]  trip_cause;
        logic [15:0] running_mask;
    } t_out_item;

    typedef struct packed {
        logic apply;
        logic tick;
        logic check;
        logic load;
    } t_stage_ctl;

    typedef struct packed {
        logic running;
        logic fire;
    } t_stage_sts;

endpackage

>>> src/dtou_stage.sv
// ----------------------------------------------------------------------------
// Definite-time stage
// Holds one stage's setting and timer, compares the sample against the
// threshold and reports time-out and the timer state after the item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtou_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dtou_pkg::t_stage_ctl i_ctl,
    input  logic [15:0]         i_sample,
    input  logic [15:0]         i_set_threshold,
    input  logic [15:0]         i_set_delay,
    output dtou_pkg::t_stage_sts o_sts
);

    logic [15:0] r_thr;
    logic [15:0] r_dly;
    logic        r_run;
    logic [15:0] r_el;
    logic        n_run;
    logic [15:0] n_el;

    logic        w_enabled;
    logic        w_over;
    logic        w_under;
    logic        w_past;
    logic        w_back;
    logic        w_start;
    logic        w_run1;
    logic [15:0] w_el1;
    logic        w_timeout;
    logic        w_stop;
    logic        w_active;
    logic        w_run_c;
    logic [15:0] w_el_c;

    always_comb begin
        w_enabled = (r_thr != 16'd0) && (r_thr != dtou_pkg::ONE_PU);
        w_over    = r_thr > dtou_pkg::ONE_PU;
        w_under   = r_thr < dtou_pkg::ONE_PU;
        w_past    = (w_over && (i_sample > r_thr)) || (w_under && (i_sample < r_thr));
        w_back    = (w_over && (i_sample < r_thr)) || (w_under && (i_sample > r_thr));
        w_start   = !r_run && w_past;
        w_run1    = r_run || w_start;
        w_el1     = w_start ? 16'd0 : r_el;
        w_timeout = w_run1 && (w_el1 >= r_dly);
        w_stop    = w_run1 && !w_timeout && w_back;
        w_active  = i_ctl.check && w_enabled;
        w_run_c   = w_active ? (w_run1 && !w_stop) : r_run;
        w_el_c    = (w_active && (w_start || w_stop)) ? 16'd0 : r_el;
        n_run     = w_run_c;
        n_el      = (i_ctl.tick && w_run_c && (w_el_c != dtou_pkg::ELAP_MAX))
                    ? w_el_c + 16'd1 : w_el_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 16'd0;
            r_dly <= 16'd0;
            r_run <= 1'b0;
            r_el  <= 16'd0;
        end else if (i_ctl.apply) begin
            r_run <= n_run;
            r_el  <= n_el;
            if (i_ctl.load) begin
                r_thr <= i_set_threshold;
                r_dly <= i_set_delay;
            end
        end
    end

    assign o_sts.running = n_run;
    assign o_sts.fire    = w_enabled && w_timeout;

endmodule

>>> src/definite_time_over_under_relay_unit.sv
// ----------------------------------------------------------------------------
// Definite-time over/under relay unit
// Four-quantity definite-time protection relay with latched trip.
// ----------------------------------------------------------------------------
// The unit accepts one item per clock cycle while the output side does not stall
// it, and returns one result item for each: the item is captured in the input
// register, all stages are evaluated in parallel from that register and
// the result is held in the output register until it is taken. Stage timers
// advance once per relay tick item, not per clock cycle.
`timescale 1ns / 1ps

module definite_time_over_under_relay_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dtou_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dtou_pkg::t_out_item o_out_item
);

    logic                r_in_valid;
    dtou_pkg::t_in_item  r_in;
    logic                r_out_valid;
    dtou_pkg::t_out_item r_out;
    dtou_pkg::t_out_item n_out;
    logic                r_trip_latch;
    logic                n_trip_latch;

    logic                w_adv;
    logic                w_tick;
    logic [15:0]         w_sample [dtou_pkg::NQ];
    logic [dtou_pkg::NQ-1:0] w_chk;
    logic [dtou_pkg::NQ-1:0] w_fired;
    logic [3:0]          w_cause;
    logic [15:0]         w_mask;

    dtou_pkg::t_stage_ctl w_ctl [dtou_pkg::NSTG];
    dtou_pkg::t_stage_sts w_sts [dtou_pkg::NSTG];

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_tick     = (r_in.func == dtou_pkg::FUNC_TICK);

    always_comb begin
        w_sample[0] = r_in.wind_speed;
        w_sample[1] = r_in.rotor_speed;
        w_sample[2] = r_in.bus_frequency;
        w_sample[3] = r_in.terminal_voltage;
    end

    always_comb begin
        w_fired = '0;
        for (int q = 0; q < dtou_pkg::NQ; q++) begin
            for (int s = 0; s < dtou_pkg::STAGES; s++) begin
                w_fired[q] = w_fired[q] || w_sts[q * dtou_pkg::STAGES + s].fire;
            end
        end
        w_chk[0] = w_tick && r_in.unit_online && !r_trip_latch;
        for (int q = 1; q < dtou_pkg::NQ; q++) begin
            w_chk[q] = w_chk[q-1] && !w_fired[q-1];
        end
        w_chk[dtou_pkg::Q_VOLTAGE] = w_chk[dtou_pkg::Q_VOLTAGE]
                                     && (r_in.terminal_voltage <= dtou_pkg::TWO_PU);
        w_cause = w_chk & w_fired;
        n_trip_latch = r_trip_latch || (w_cause != 4'd0);
    end

    for (genvar q = 0; q < dtou_pkg::NQ; q++) begin : g_qty
        for (genvar s = 0; s < dtou_pkg::STAGES; s++) begin : g_stg
            localparam int K = q * dtou_pkg::STAGES + s;
            always_comb begin
                w_ctl[K].apply = w_adv;
                w_ctl[K].tick  = w_tick;
                w_ctl[K].check = w_chk[q];
                w_ctl[K].load  = (r_in.func == dtou_pkg::FUNC_LOAD)
                                 && (32'(r_in.set_quantity) == q)
                                 && (32'(r_in.set_stage) == s);
            end
            dtou_stage u_stage (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctl          (w_ctl[K]),
                .i_sample       (w_sample[q]),
                .i_set_threshold(r_in.set_threshold),
                .i_set_delay    (r_in.set_delay),
                .o_sts          (w_sts[K])
            );
        end
    end

    always_comb begin
        w_mask = '0;
        for (int k = 0; k < dtou_pkg::NMASK; k++) begin
            w_mask[k] = w_sts[k].running;
        end
        n_out.tripped      = n_trip_latch;
        n_out.trip_now     = (w_cause != 4'd0);
        n_out.trip_cause   = w_cause;
        n_out.running_mask = w_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_trip_latch <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid  <= 1'b1;
                r_trip_latch <= n_trip_latch;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_latch_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trip_latch |=> r_trip_latch)
        else $error("Trip latch cleared without reset.");

    a_trip_sets_tripped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.trip_now) |-> o_out_item.tripped)
        else $error("Trip reported without the latched trip.");

    a_single_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_out_item.trip_cause))
        else $error("More than one quantity reported as trip cause.");

    a_load_no_trip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_in.func == dtou_pkg::FUNC_LOAD)) |=> !o_out_item.trip_now)
        else $error("Setting load item reported a trip.");

    a_tripped_no_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trip_latch |-> (w_chk == '0))
        else $error("Stages checked while the unit is tripped.");

endmodule
